// File: hdl/scsd_pkg.sv
// shared types and constants for the sparse column squared distance block
package scsd_pkg;

  // field widths
  localparam int RowW  = 10;
  localparam int ValW  = 16;
  localparam int NormW = 47;
  localparam int DataW = 48;
  localparam int ColW  = 16;
  localparam int ProdW = 2 * ValW;
  localparam int AccW  = DataW + 1;
  localparam int DistW = DataW + 2;

  // rows reachable by the row index field
  localparam int RowSpan = 1 << RowW;

  // default centroid length
  localparam int VectorLength = 1024;

  // stream payload widths
  localparam int InDataW  = 80;
  localparam int OutDataW = 112;

  // configuration port
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 4;
  localparam int CfgIdxLsb = 3;

  // register indexes
  localparam logic RegCentroidNorm = 1'b0;

  // item kinds carried on the input tuser
  localparam logic ModeLoad    = 1'b0;
  localparam logic ModeNonzero = 1'b1;

  // signed 48-bit limits
  localparam logic signed [DataW-1:0] Max48 = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] Min48 = {1'b1, {(DataW-1){1'b0}}};

  // finished column handed from the accumulator to the distance stage
  typedef struct packed {
    logic signed [DataW-1:0] dot;
    logic                    ovf;
    logic [NormW-1:0]        cnorm;
  } res_t;

endpackage

// File: hdl/scsd_cfg_regs.sv
// configuration register file behind the apb-style port
module scsd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [scsd_pkg::CfgAddrW-1:0]  paddr_i,
  input  logic [scsd_pkg::CfgDataW-1:0]  pwdata_i,
  output logic [scsd_pkg::CfgDataW-1:0]  prdata_o,
  output logic [scsd_pkg::NormW-1:0]     centroid_norm_o
);

  logic [scsd_pkg::NormW-1:0] centroid_norm_q;
  logic                       sel_norm;

  // register decode on the word index
  assign sel_norm = (paddr_i[scsd_pkg::CfgAddrW-1:scsd_pkg::CfgIdxLsb]
                     == scsd_pkg::RegCentroidNorm);

  // write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centroid_norm_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && sel_norm) begin
      centroid_norm_q <= pwdata_i[scsd_pkg::NormW-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata_o = '0;
    if (sel_norm) begin
      prdata_o = scsd_pkg::CfgDataW'(centroid_norm_q);
    end
  end

  assign centroid_norm_o = centroid_norm_q;

endmodule

// File: hdl/scsd_centroid_mem.sv
// centroid element store, one write and one registered read port
module scsd_centroid_mem #(
  parameter int Depth = scsd_pkg::VectorLength,
  parameter int AddrW = $clog2(scsd_pkg::VectorLength)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AddrW-1:0]                 waddr_i,
  input  logic signed [scsd_pkg::ValW-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AddrW-1:0]                 raddr_i,
  output logic signed [scsd_pkg::ValW-1:0] rdata_o
);

  logic signed [scsd_pkg::ValW-1:0] mem_q [Depth];
  logic signed [scsd_pkg::ValW-1:0] rdata_q;

  // write, and a registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/scsd_mac.sv
// multiply-accumulate pipeline over the column nonzeros
module scsd_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic signed [scsd_pkg::ValW-1:0]  val_i,
  input  logic                              in_range_i,
  input  logic                              last_i,
  input  logic [scsd_pkg::NormW-1:0]        cnorm_i,
  input  logic signed [scsd_pkg::ValW-1:0]  cval_i,
  output logic                              ready_o,
  output logic                              res_valid_o,
  output scsd_pkg::res_t                    res_o,
  input  logic                              res_ready_i
);

  // stage 1: operands waiting for the centroid read
  logic                             v1_q;
  logic signed [scsd_pkg::ValW-1:0] val1_q;
  logic                             inr1_q;
  logic                             last1_q;
  logic [scsd_pkg::NormW-1:0]       cnorm1_q;

  // stage 2: registered product
  logic                              v2_q;
  logic signed [scsd_pkg::ProdW-1:0] prod2_q;
  logic                              last2_q;
  logic [scsd_pkg::NormW-1:0]        cnorm2_q;

  // running column state
  logic signed [scsd_pkg::DataW-1:0] acc_q;
  logic                              ovf_q;

  // stage 3: finished column
  logic           v3_q;
  scsd_pkg::res_t res_q;

  logic                              r2, r3, adv1, move2;
  logic signed [scsd_pkg::ValW-1:0]  cval;
  logic signed [scsd_pkg::AccW-1:0]  sum;
  logic signed [scsd_pkg::DataW-1:0] acc_sat;
  logic                              acc_cl;

  // flow control, stage 2 drains freely unless it holds a column end
  assign r3      = !v3_q || res_ready_i;
  assign r2      = !v2_q || !last2_q || r3;
  assign ready_o = !v1_q || r2;
  assign adv1    = v1_q && r2;
  assign move2   = v2_q && r2;

  // rows beyond the vector read as zero
  assign cval = inr1_q ? cval_i : '0;

  // saturating accumulate
  always_comb begin
    sum     = scsd_pkg::AccW'(acc_q) + scsd_pkg::AccW'(prod2_q);
    acc_cl  = (sum[scsd_pkg::AccW-1] != sum[scsd_pkg::AccW-2]);
    acc_sat = sum[scsd_pkg::DataW-1:0];
    if (acc_cl) begin
      acc_sat = sum[scsd_pkg::AccW-1] ? scsd_pkg::Min48 : scsd_pkg::Max48;
    end
  end

  // valid bits and column state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (load_i) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= move2 && last2_q;
      end
      if (move2) begin
        if (last2_q) begin
          acc_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          acc_q <= acc_sat;
          ovf_q <= ovf_q || acc_cl;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val1_q   <= val_i;
      inr1_q   <= in_range_i;
      last1_q  <= last_i;
      cnorm1_q <= cnorm_i;
    end
    if (adv1) begin
      prod2_q  <= val1_q * cval;
      last2_q  <= last1_q;
      cnorm2_q <= cnorm1_q;
    end
    if (move2 && last2_q && r3) begin
      res_q.dot   <= acc_sat;
      res_q.ovf   <= ovf_q || acc_cl;
      res_q.cnorm <= cnorm2_q;
    end
  end

  assign res_valid_o = v3_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // column end clears the running sum and overflow mark
  a_col_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && last2_q && r3) |=> (acc_q == '0 && !ovf_q))
    else $error("accumulator not cleared after column end");

  // a stalled operand keeps its slot and read data
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !r2) |=> (v1_q && $stable(val1_q) && $stable(cval_i)))
    else $error("stage 1 lost its operand while stalled");
`endif

endmodule

// File: hdl/scsd_dist.sv
// distance, saturation and output register
module scsd_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                res_valid_i,
  input  scsd_pkg::res_t                      res_i,
  output logic                                res_ready_o,
  input  logic [scsd_pkg::NormW-1:0]          centroid_norm_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [scsd_pkg::OutDataW-1:0]       out_data_o,
  output logic                                out_sat_o
);

  logic                              ov_q;
  logic [scsd_pkg::ColW-1:0]         col_q;
  logic [scsd_pkg::ColW-1:0]         col_out_q;
  logic signed [scsd_pkg::DataW-1:0] dot_q;
  logic signed [scsd_pkg::DataW-1:0] dist_q;
  logic                              sat_q;

  logic                              load;
  logic signed [scsd_pkg::DistW-1:0] dist_full;
  logic signed [scsd_pkg::DataW-1:0] dist_sat;
  logic                              dist_cl;

  assign res_ready_o = !ov_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  // column_norm + centroid_norm - 2*dot, clamped to 48 bits
  always_comb begin
    dist_full = $signed({2'b00, 1'b0, res_i.cnorm})
              + $signed({2'b00, 1'b0, centroid_norm_i})
              - $signed({res_i.dot[scsd_pkg::DataW-1], res_i.dot, 1'b0});
    dist_cl   = !((dist_full[scsd_pkg::DistW-1:scsd_pkg::DataW-1] == '0) ||
                  (dist_full[scsd_pkg::DistW-1:scsd_pkg::DataW-1] == '1));
    dist_sat  = dist_full[scsd_pkg::DataW-1:0];
    if (dist_cl) begin
      dist_sat = dist_full[scsd_pkg::DistW-1] ? scsd_pkg::Min48 : scsd_pkg::Max48;
    end
  end

  // output valid and column counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      col_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        col_q <= col_q + 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      col_out_q <= col_q;
      dot_q     <= res_i.dot;
      dist_q    <= dist_sat;
      sat_q     <= dist_cl || res_i.ovf;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {dist_q, dot_q, col_out_q};
  assign out_sat_o   = sat_q;

`ifndef SYNTHESIS
  // each result takes the next column number
  a_col_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (col_q == $past(col_q) + 1'b1 && col_out_q == $past(col_q)))
    else $error("column number did not advance with a result");
`endif

endmodule

// File: hdl/sparse_column_squared_distance.sv
// top level: sparse column dot product and squared distance to a stored centroid
// one item accepted per cycle unless a column end is held by result back-pressure; centroid loads finish on acceptance
// a column end reaches m_axis_tvalid through the operand, product, column result and output registers
// stages: centroid memory read, 16x16 multiply, accumulate, distance and output register
// asynchronous active-low reset clears valids, accumulator, column counter and centroid_norm
// the centroid memory is not cleared; every element must be loaded before it is used, which the block does not enforce
module sparse_column_squared_distance #(
  parameter int VECTOR_LENGTH = scsd_pkg::VectorLength
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row_index[9:0], value[25:10], column_norm[72:26], zero fill
  input  logic [scsd_pkg::InDataW-1:0]   s_axis_tdata,
  // mode[0]
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // column_number[15:0], dot_product[63:16], distance[111:64]
  output logic [scsd_pkg::OutDataW-1:0]  m_axis_tdata,
  // saturated[0]
  output logic                           m_axis_tuser,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scsd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [scsd_pkg::CfgDataW-1:0]  pwdata,
  output logic [scsd_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);

  localparam int Depth = (VECTOR_LENGTH < scsd_pkg::RowSpan) ? VECTOR_LENGTH
                                                             : scsd_pkg::RowSpan;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [scsd_pkg::RowW-1:0]        row;
  logic signed [scsd_pkg::ValW-1:0] val;
  logic [scsd_pkg::NormW-1:0]       cnorm;
  logic                             accept;
  logic                             in_range;
  logic                             mem_we;
  logic                             mem_re;
  logic signed [scsd_pkg::ValW-1:0] cval;
  logic [scsd_pkg::NormW-1:0]       centroid_norm;
  logic                             res_valid;
  logic                             res_ready;
  scsd_pkg::res_t                   res;

  // unpack the input item
  assign row   = s_axis_tdata[scsd_pkg::RowW-1:0];
  assign val   = s_axis_tdata[scsd_pkg::RowW +: scsd_pkg::ValW];
  assign cnorm = s_axis_tdata[scsd_pkg::RowW + scsd_pkg::ValW +: scsd_pkg::NormW];

  // transaction and row decode
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_range = (32'(row) < 32'(VECTOR_LENGTH));
  assign mem_we   = accept && (s_axis_tuser == scsd_pkg::ModeLoad) && in_range;
  assign mem_re   = accept && (s_axis_tuser == scsd_pkg::ModeNonzero);

  assign pready = 1'b1;

  scsd_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .centroid_norm_o (centroid_norm)
  );

  scsd_centroid_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (row[AddrW-1:0]),
    .wdata_i (val),
    .re_i    (mem_re),
    .raddr_i (row[AddrW-1:0]),
    .rdata_o (cval)
  );

  scsd_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (mem_re),
    .val_i       (val),
    .in_range_i  (in_range),
    .last_i      (s_axis_tlast),
    .cnorm_i     (cnorm),
    .cval_i      (cval),
    .ready_o     (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  scsd_dist u_dist (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .res_ready_o     (res_ready),
    .centroid_norm_i (centroid_norm),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_sat_o       (m_axis_tuser)
  );

endmodule
